>>> hw/rtl/sixs_pkg.sv
// ---------------------------------------------------------------------------
// sixs_pkg
// Shared constants, codes and controller/datapath interface types for the
// segment index block.
// ---------------------------------------------------------------------------
package sixs_pkg;

    localparam int DEPTH     = 32;
    localparam int TIME_BITS = 48;
    localparam int MAX_OUT   = 32;

    localparam int T_W       = 48;
    localparam int ID_W      = 32;
    localparam int ENTRY_W   = 2 * T_W + ID_W;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OCNT_W    = $clog2(MAX_OUT + 1);
    localparam int KEY_W     = T_W + ID_W + ADDR_W;

    localparam logic [T_W-1:0] TIME_MASK =
        (TIME_BITS >= T_W) ? {T_W{1'b1}} : ((T_W'(1) << TIME_BITS) - T_W'(1));

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_WINDOW = 2'd2,
        FUNC_SEEK   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CODE_DONE   = 3'd0,
        CODE_FULL   = 3'd1,
        CODE_LISTED = 3'd2,
        CODE_NONE   = 3'd3,
        CODE_INSIDE = 3'd4,
        CODE_GAP    = 3'd5
    } t_code;

    typedef enum logic [1:0] {
        EMIT_NOTHING = 2'd0,
        EMIT_PEND    = 2'd1,
        EMIT_EMPTY   = 2'd2,
        EMIT_SEEK    = 2'd3
    } t_emit;

    typedef struct packed {
        logic  do_clear;
        logic  do_load;
        logic  query_start;
        logic  pass_clr;
        logic  scan_en;
        logic  take_best;
        t_emit emit;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic best_vld;
        logic pend_vld;
        logic cap_hit;
        logic is_window;
    } t_status;

endpackage

>>> hw/rtl/sixs_ram.sv
// ---------------------------------------------------------------------------
// sixs_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module sixs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sixs_ctrl.sv
// ---------------------------------------------------------------------------
// sixs_ctrl
// Controller: sequences clear/load, table scan passes and result emission.
// ---------------------------------------------------------------------------
module sixs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_func,
    input  sixs_pkg::t_status i_status,
    output sixs_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_END  = 3'b100
    } t_state;

    t_state         r_state;
    t_state         n_state;
    sixs_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.emit = sixs_pkg::EMIT_NOTHING;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (sixs_pkg::t_func'(i_func))
                        sixs_pkg::FUNC_CLEAR: cmd.do_clear = 1'b1;
                        sixs_pkg::FUNC_LOAD:  cmd.do_load  = 1'b1;
                        default: begin
                            cmd.query_start = 1'b1;
                            cmd.pass_clr    = 1'b1;
                            n_state         = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (!i_status.is_window) begin
                    cmd.emit      = sixs_pkg::EMIT_SEEK;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_status.best_vld && i_status.pend_vld && i_status.cap_hit) begin
                    // list is full, the held entry closes it
                    cmd.emit      = sixs_pkg::EMIT_PEND;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_status.best_vld) begin
                    // another hit exists, so the held one is not the last
                    if (i_status.pend_vld) begin
                        cmd.emit = sixs_pkg::EMIT_PEND;
                    end
                    cmd.take_best = 1'b1;
                    cmd.pass_clr  = 1'b1;
                    n_state       = S_SCAN;
                end else if (i_status.pend_vld) begin
                    cmd.emit      = sixs_pkg::EMIT_PEND;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.emit      = sixs_pkg::EMIT_EMPTY;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

>>> hw/rtl/sixs_dp.sv
// ---------------------------------------------------------------------------
// sixs_dp
// Datapath: segment table, scan compare stage, best/held entry registers
// and result registers.
// ---------------------------------------------------------------------------
module sixs_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sixs_pkg::t_cmd               i_cmd,
    input  logic [1:0]                   i_func,
    input  logic [sixs_pkg::T_W-1:0]     i_seg_start,
    input  logic [sixs_pkg::T_W-1:0]     i_seg_end,
    input  logic [sixs_pkg::ID_W-1:0]    i_seg_id,
    input  logic [sixs_pkg::T_W-1:0]     i_window_from,
    input  logic [sixs_pkg::T_W-1:0]     i_window_to,
    input  logic [sixs_pkg::T_W-1:0]     i_seek_at,
    output sixs_pkg::t_status            o_status,
    output logic                         o_valid,
    output logic [2:0]                   o_result_code,
    output logic [sixs_pkg::T_W-1:0]     o_out_start,
    output logic [sixs_pkg::T_W-1:0]     o_out_end,
    output logic [sixs_pkg::ID_W-1:0]    o_out_id,
    output logic [sixs_pkg::T_W-1:0]     o_offset_ms,
    output logic                         o_last_of_run
);

    localparam int T_W    = sixs_pkg::T_W;
    localparam int ID_W   = sixs_pkg::ID_W;
    localparam int AW     = sixs_pkg::ADDR_W;
    localparam int CW     = sixs_pkg::CNT_W;
    localparam int OW     = sixs_pkg::OCNT_W;
    localparam int KW     = sixs_pkg::KEY_W;

    // table occupancy and scan pointer
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_addr;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;

    // query operands
    logic            r_is_window;
    logic [T_W-1:0]  r_from;
    logic [T_W-1:0]  r_to;
    logic [T_W-1:0]  r_at;

    // best candidate of the current pass
    logic            r_best_vld;
    logic [T_W-1:0]  r_best_start;
    logic [T_W-1:0]  r_best_end;
    logic [ID_W-1:0] r_best_id;
    logic [AW-1:0]   r_best_idx;

    // entry found by the previous pass, not yet sent
    logic            r_pend_vld;
    logic [T_W-1:0]  r_pend_start;
    logic [T_W-1:0]  r_pend_end;
    logic [ID_W-1:0] r_pend_id;
    logic [AW-1:0]   r_pend_idx;
    logic [OW-1:0]   r_emit_cnt;

    logic            r_o_valid;
    logic [2:0]      r_o_code;
    logic [T_W-1:0]  r_o_start;
    logic [T_W-1:0]  r_o_end;
    logic [ID_W-1:0] r_o_id;
    logic [T_W-1:0]  r_o_offset;
    logic            r_o_last;

    logic                        table_full;
    logic                        ram_we;
    logic [sixs_pkg::ENTRY_W-1:0] ram_wdata;
    logic [sixs_pkg::ENTRY_W-1:0] ram_rdata;
    logic [T_W-1:0]              rd_start;
    logic [T_W-1:0]              rd_end;
    logic [ID_W-1:0]             rd_id;
    logic [KW-1:0]               rd_key;
    logic [KW-1:0]               best_key;
    logic [KW-1:0]               pend_key;
    logic                        hit_win;
    logic                        hit_seek;
    logic                        take_rd;
    logic                        seek_inside;

    assign table_full = (r_count >= CW'(sixs_pkg::DEPTH));
    assign ram_we     = i_cmd.do_load && !table_full;
    assign ram_wdata  = {i_seg_start & sixs_pkg::TIME_MASK,
                         i_seg_end & sixs_pkg::TIME_MASK,
                         i_seg_id};

    sixs_ram #(
        .WIDTH (sixs_pkg::ENTRY_W),
        .DEPTH (sixs_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign {rd_start, rd_end, rd_id} = ram_rdata;

    // sort key: start, then id, then load position
    assign rd_key   = {rd_start, rd_id, r_rd_idx};
    assign best_key = {r_best_start, r_best_id, r_best_idx};
    assign pend_key = {r_pend_start, r_pend_id, r_pend_idx};

    assign hit_win  = (rd_start < r_to) && (r_from < rd_end)
                      && (!r_pend_vld || (rd_key > pend_key));
    assign hit_seek = ((r_at >= rd_start) && (r_at < rd_end)) || (rd_start >= r_at);
    assign take_rd  = r_rd_vld && (r_is_window ? hit_win : hit_seek)
                      && (!r_best_vld || (rd_key < best_key));

    assign seek_inside = (r_at >= r_best_start) && (r_at < r_best_end);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_emit_cnt <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.do_clear || i_cmd.do_load
                         || (i_cmd.emit != sixs_pkg::EMIT_NOTHING);
            if (i_cmd.do_clear) begin
                r_count <= '0;
            end
            if (i_cmd.do_load) begin
                if (!table_full) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.query_start) begin
                r_pend_vld <= 1'b0;
                r_emit_cnt <= '0;
            end
            if (i_cmd.pass_clr) begin
                r_addr     <= '0;
                r_rd_vld   <= 1'b0;
                r_best_vld <= 1'b0;
            end else begin
                if (i_cmd.scan_en) begin
                    r_rd_vld <= (r_addr != r_count);
                    if (r_addr != r_count) begin
                        r_addr <= r_addr + CW'(1);
                    end
                end
                if (take_rd) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.take_best) begin
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.emit == sixs_pkg::EMIT_PEND) begin
                r_emit_cnt <= r_emit_cnt + OW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en) begin
            r_rd_idx <= r_addr[AW-1:0];
        end
        if (i_cmd.query_start) begin
            r_is_window <= (sixs_pkg::t_func'(i_func) == sixs_pkg::FUNC_WINDOW);
            r_from      <= i_window_from & sixs_pkg::TIME_MASK;
            r_to        <= i_window_to & sixs_pkg::TIME_MASK;
            r_at        <= i_seek_at & sixs_pkg::TIME_MASK;
        end
        if (take_rd && !i_cmd.pass_clr) begin
            r_best_start <= rd_start;
            r_best_end   <= rd_end;
            r_best_id    <= rd_id;
            r_best_idx   <= r_rd_idx;
        end
        if (i_cmd.take_best) begin
            r_pend_start <= r_best_start;
            r_pend_end   <= r_best_end;
            r_pend_id    <= r_best_id;
            r_pend_idx   <= r_best_idx;
        end

        if (i_cmd.do_clear || i_cmd.do_load) begin
            r_o_code   <= (i_cmd.do_load && table_full) ? sixs_pkg::CODE_FULL
                                                        : sixs_pkg::CODE_DONE;
            r_o_start  <= '0;
            r_o_end    <= '0;
            r_o_id     <= '0;
            r_o_offset <= '0;
            r_o_last   <= 1'b1;
        end else begin
            case (i_cmd.emit)
                sixs_pkg::EMIT_PEND: begin
                    r_o_code   <= sixs_pkg::CODE_LISTED;
                    r_o_start  <= r_pend_start;
                    r_o_end    <= r_pend_end;
                    r_o_id     <= r_pend_id;
                    r_o_offset <= '0;
                    r_o_last   <= i_cmd.emit_last;
                end
                sixs_pkg::EMIT_EMPTY: begin
                    r_o_code   <= sixs_pkg::CODE_NONE;
                    r_o_start  <= '0;
                    r_o_end    <= '0;
                    r_o_id     <= '0;
                    r_o_offset <= '0;
                    r_o_last   <= i_cmd.emit_last;
                end
                sixs_pkg::EMIT_SEEK: begin
                    r_o_last <= i_cmd.emit_last;
                    if (!r_best_vld) begin
                        r_o_code   <= sixs_pkg::CODE_NONE;
                        r_o_start  <= '0;
                        r_o_end    <= '0;
                        r_o_id     <= '0;
                        r_o_offset <= '0;
                    end else begin
                        r_o_code   <= seek_inside ? sixs_pkg::CODE_INSIDE
                                                  : sixs_pkg::CODE_GAP;
                        r_o_start  <= r_best_start;
                        r_o_end    <= r_best_end;
                        r_o_id     <= r_best_id;
                        r_o_offset <= seek_inside ? (r_at - r_best_start) : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status.scan_done = (r_addr == r_count);
    assign o_status.best_vld  = r_best_vld;
    assign o_status.pend_vld  = r_pend_vld;
    assign o_status.cap_hit   = (r_emit_cnt == OW'(sixs_pkg::MAX_OUT - 1));
    assign o_status.is_window = r_is_window;

    assign o_valid       = r_o_valid;
    assign o_result_code = r_o_code;
    assign o_out_start   = r_o_start;
    assign o_out_end     = r_o_end;
    assign o_out_id      = r_o_id;
    assign o_offset_ms   = r_o_offset;
    assign o_last_of_run = r_o_last;

endmodule

>>> hw/rtl/segment_index_window_and_seek.sv
// ---------------------------------------------------------------------------
// segment_index_window_and_seek
// Table of time segments with clear, load, window query and seek commands.
// ---------------------------------------------------------------------------
// Usage: drive i_func and its operands with start high; the command is
// transferred at a clock edge where start is high and busy is low.
// Results come out one per cycle at most, each marked by o_valid for a
// single cycle; o_last_of_run marks the final result of a command. The
// receiver cannot stall the block, so results must be taken as they come.
// Clear and load: one result in the cycle after the transfer, busy stays low,
//   so a new command can follow in the next cycle.
// Seek: one scan over all stored entries, one result.
// Window query: each selection pass over the stored entries finds the next
//   segment in (start, id, load order); each listed segment is sent after the
//   following pass, and an empty answer is sent after a single pass.
// The scan rate is set by the single read port of the segment table: one
// entry compared per cycle.
// Reset (synchronous, active low) empties the table and returns to idle;
// table contents are not cleared, only the entry count.
// ---------------------------------------------------------------------------
module segment_index_window_and_seek (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_func,
    input  logic [sixs_pkg::T_W-1:0]  i_seg_start,
    input  logic [sixs_pkg::T_W-1:0]  i_seg_end,
    input  logic [sixs_pkg::ID_W-1:0] i_seg_id,
    input  logic [sixs_pkg::T_W-1:0]  i_window_from,
    input  logic [sixs_pkg::T_W-1:0]  i_window_to,
    input  logic [sixs_pkg::T_W-1:0]  i_seek_at,
    output logic                      o_valid,
    output logic [2:0]                o_result_code,
    output logic [sixs_pkg::T_W-1:0]  o_out_start,
    output logic [sixs_pkg::T_W-1:0]  o_out_end,
    output logic [sixs_pkg::ID_W-1:0] o_out_id,
    output logic [sixs_pkg::T_W-1:0]  o_offset_ms,
    output logic                      o_last_of_run
);

    sixs_pkg::t_cmd    cmd;
    sixs_pkg::t_status status;
    logic              ctrl_busy;

    sixs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    sixs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_seg_start   (i_seg_start),
        .i_seg_end     (i_seg_end),
        .i_seg_id      (i_seg_id),
        .i_window_from (i_window_from),
        .i_window_to   (i_window_to),
        .i_seek_at     (i_seek_at),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_result_code (o_result_code),
        .o_out_start   (o_out_start),
        .o_out_end     (o_out_end),
        .o_out_id      (o_out_id),
        .o_offset_ms   (o_offset_ms),
        .o_last_of_run (o_last_of_run)
    );

    assign busy = ctrl_busy;

    // clear and load answer in the next cycle with a single closing result
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == sixs_pkg::FUNC_CLEAR || i_func == sixs_pkg::FUNC_LOAD))
        |=> (o_valid && o_last_of_run))
        else $error("clear/load result missing");

    // a listed segment that is not the last one leaves the block scanning
    a_list_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_code == sixs_pkg::CODE_LISTED && !o_last_of_run) |-> busy)
        else $error("idle after a non-final listed segment");

    // seek answers are always single results
    a_seek_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_code == sixs_pkg::CODE_INSIDE
                     || o_result_code == sixs_pkg::CODE_GAP)) |-> o_last_of_run)
        else $error("seek result not final");

    // offset only carries a value for a seek inside a segment
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_code != sixs_pkg::CODE_INSIDE) |-> (o_offset_ms == '0))
        else $error("nonzero offset outside a seek hit");

endmodule

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the segment index: a queue of commands feeds a
// clocked driver, a local model of the table predicts every result, and a
// clocked monitor compares each strobed result with the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int T_W     = sixs_pkg::T_W;
    localparam int ID_W    = sixs_pkg::ID_W;
    localparam int DEPTH   = sixs_pkg::DEPTH;
    localparam int MAX_OUT = sixs_pkg::MAX_OUT;

    localparam logic [T_W-1:0] TIME_MASK = sixs_pkg::TIME_MASK;
    localparam logic [T_W-1:0] TIME_MAX  = {T_W{1'b1}};

    typedef sixs_pkg::t_func t_func;
    typedef sixs_pkg::t_code t_code;

    typedef struct {
        t_func           func;
        logic [T_W-1:0]  seg_start;
        logic [T_W-1:0]  seg_end;
        logic [ID_W-1:0] seg_id;
        logic [T_W-1:0]  window_from;
        logic [T_W-1:0]  window_to;
        logic [T_W-1:0]  seek_at;
    } t_seg_cmd;

    typedef struct {
        t_code           code;
        logic [T_W-1:0]  seg_start;
        logic [T_W-1:0]  seg_end;
        logic [ID_W-1:0] seg_id;
        logic [T_W-1:0]  offset;
        logic            last_of_run;
    } t_seg_result;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            start         = 1'b0;
    logic [1:0]      i_func        = '0;
    logic [T_W-1:0]  i_seg_start   = '0;
    logic [T_W-1:0]  i_seg_end     = '0;
    logic [ID_W-1:0] i_seg_id      = '0;
    logic [T_W-1:0]  i_window_from = '0;
    logic [T_W-1:0]  i_window_to   = '0;
    logic [T_W-1:0]  i_seek_at     = '0;
    logic            busy;
    logic            o_valid;
    logic [2:0]      o_result_code;
    logic [T_W-1:0]  o_out_start;
    logic [T_W-1:0]  o_out_end;
    logic [ID_W-1:0] o_out_id;
    logic [T_W-1:0]  o_offset_ms;
    logic            o_last_of_run;

    segment_index_window_and_seek dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_seg_cmd    cmd_queue[$];
    t_seg_result expected_results[$];
    logic [T_W-1:0] gen_points[$];
    int error_count    = 0;
    int accepted_count = 0;
    int total_count    = 0;
    int idle_left      = 0;
    int calm_left      = 0;

    // local copy of the segment table
    logic [T_W-1:0]  tbl_start [DEPTH];
    logic [T_W-1:0]  tbl_end   [DEPTH];
    logic [ID_W-1:0] tbl_id    [DEPTH];
    int              tbl_count = 0;

    function automatic logic [T_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[T_W-1:0];
    endfunction

    function automatic t_seg_cmd noise_cmd(t_func f);
        t_seg_cmd c;
        c.func        = f;
        c.seg_start   = rand48();
        c.seg_end     = rand48();
        c.seg_id      = $urandom();
        c.window_from = rand48();
        c.window_to   = rand48();
        c.seek_at     = rand48();
        return c;
    endfunction

    task automatic queue_cmd(t_seg_cmd c);
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic note_point(logic [T_W-1:0] p);
        gen_points.insert(gen_points.size(), p);
    endtask

    task automatic add_clear();
        queue_cmd(noise_cmd(sixs_pkg::FUNC_CLEAR));
        gen_points.delete();
    endtask

    task automatic add_load(logic [T_W-1:0] s, logic [T_W-1:0] e, logic [ID_W-1:0] id);
        t_seg_cmd c;
        c = noise_cmd(sixs_pkg::FUNC_LOAD);
        c.seg_start = s;
        c.seg_end   = e;
        c.seg_id    = id;
        queue_cmd(c);
        note_point(s);
        note_point(e);
    endtask

    task automatic add_window(logic [T_W-1:0] wf, logic [T_W-1:0] wt);
        t_seg_cmd c;
        c = noise_cmd(sixs_pkg::FUNC_WINDOW);
        c.window_from = wf;
        c.window_to   = wt;
        queue_cmd(c);
    endtask

    task automatic add_seek(logic [T_W-1:0] at);
        t_seg_cmd c;
        c = noise_cmd(sixs_pkg::FUNC_SEEK);
        c.seek_at = at;
        queue_cmd(c);
    endtask

    // strict (start, id) order; equal keys keep load order
    function automatic bit orders_first(int a, int b);
        if (tbl_start[a] != tbl_start[b])
            return tbl_start[a] < tbl_start[b];
        return tbl_id[a] < tbl_id[b];
    endfunction

    task automatic push_result(t_code code, int idx, bit seg, logic [T_W-1:0] offset,
                               bit last_of_run);
        t_seg_result r;
        r.code        = code;
        r.seg_start   = seg ? tbl_start[idx] : '0;
        r.seg_end     = seg ? tbl_end[idx]   : '0;
        r.seg_id      = seg ? tbl_id[idx]    : '0;
        r.offset      = offset;
        r.last_of_run = last_of_run;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic predict_segment_results(t_seg_cmd c);
        int hits[$];
        int pos;
        int best;
        int n_out;
        bit found;
        bit in_seg;
        bit ahead;
        logic [T_W-1:0] wf;
        logic [T_W-1:0] wt;
        logic [T_W-1:0] at;
        case (c.func)
            sixs_pkg::FUNC_CLEAR: begin
                tbl_count = 0;
                push_result(sixs_pkg::CODE_DONE, 0, 1'b0, '0, 1'b1);
            end
            sixs_pkg::FUNC_LOAD: begin
                if (tbl_count < DEPTH) begin
                    tbl_start[tbl_count] = c.seg_start & TIME_MASK;
                    tbl_end[tbl_count]   = c.seg_end & TIME_MASK;
                    tbl_id[tbl_count]    = c.seg_id;
                    tbl_count++;
                    push_result(sixs_pkg::CODE_DONE, 0, 1'b0, '0, 1'b1);
                end else begin
                    push_result(sixs_pkg::CODE_FULL, 0, 1'b0, '0, 1'b1);
                end
            end
            sixs_pkg::FUNC_WINDOW: begin
                wf = c.window_from & TIME_MASK;
                wt = c.window_to & TIME_MASK;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_start[i] < wt && wf < tbl_end[i]) begin
                        pos = hits.size();
                        for (int j = 0; j < hits.size(); j++) begin
                            if (orders_first(i, hits[j])) begin
                                pos = j;
                                break;
                            end
                        end
                        hits.insert(pos, i);
                    end
                end
                if (hits.size() == 0) begin
                    push_result(sixs_pkg::CODE_NONE, 0, 1'b0, '0, 1'b1);
                end else begin
                    n_out = (hits.size() < MAX_OUT) ? hits.size() : MAX_OUT;
                    for (int k = 0; k < n_out; k++)
                        push_result(sixs_pkg::CODE_LISTED, hits[k], 1'b1, '0,
                                    k == n_out - 1);
                end
            end
            default: begin
                at    = c.seek_at & TIME_MASK;
                found = 1'b0;
                best  = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    in_seg = at >= tbl_start[i] && at < tbl_end[i];
                    ahead  = tbl_start[i] >= at;
                    if ((in_seg || ahead) && (!found || orders_first(i, best))) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    push_result(sixs_pkg::CODE_NONE, 0, 1'b0, '0, 1'b1);
                else if (at >= tbl_start[best] && at < tbl_end[best])
                    push_result(sixs_pkg::CODE_INSIDE, best, 1'b1, at - tbl_start[best],
                                1'b1);
                else
                    push_result(sixs_pkg::CODE_GAP, best, 1'b1, '0, 1'b1);
            end
        endcase
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // driver: one command per transfer, random gaps between transfers
    always @(posedge i_clk) begin : drive
        t_seg_cmd next_cmd;
        int r;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                next_cmd.func        = t_func'(i_func);
                next_cmd.seg_start   = i_seg_start;
                next_cmd.seg_end     = i_seg_end;
                next_cmd.seg_id      = i_seg_id;
                next_cmd.window_from = i_window_from;
                next_cmd.window_to   = i_window_to;
                next_cmd.seek_at     = i_seek_at;
                predict_segment_results(next_cmd);
                accepted_count++;
            end
            if (start && busy) begin
                // hold the command until the block takes it
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                next_cmd      = cmd_queue.pop_front();
                i_func        <= next_cmd.func;
                i_seg_start   <= next_cmd.seg_start;
                i_seg_end     <= next_cmd.seg_end;
                i_seg_id      <= next_cmd.seg_id;
                i_window_from <= next_cmd.window_from;
                i_window_to   <= next_cmd.window_to;
                i_seek_at     <= next_cmd.seek_at;
                start         <= 1'b1;
                r = $urandom_range(0, 99);
                if (calm_left > 0) begin
                    calm_left--;
                    idle_left <= 0;
                end else if (r < 4) begin
                    calm_left = 30;
                    idle_left <= 0;
                end else if (r < 60) begin
                    idle_left <= 0;
                end else if (r < 92) begin
                    idle_left <= $urandom_range(1, 3);
                end else begin
                    idle_left <= $urandom_range(10, 60);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result is matched against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_seg_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: code %0d start %0h id %0h",
                       o_result_code, o_out_start, o_out_id);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_code", want.code, o_result_code);
                check_field("out_start", want.seg_start, o_out_start);
                check_field("out_end", want.seg_end, o_out_end);
                check_field("out_id", want.seg_id, o_out_id);
                check_field("offset_ms", want.offset, o_offset_ms);
                check_field("last_of_run", want.last_of_run, o_last_of_run);
            end
        end
    end

    initial begin
        int n_directed;
        int nloads;
        int nq;
        int sel;
        logic [T_W-1:0] epoch;
        logic [T_W-1:0] s;
        logic [T_W-1:0] e;
        logic [T_W-1:0] pt;
        logic [T_W-1:0] wt;
        logic [ID_W-1:0] id;

        // directed: empty table, extreme values, ties, reversed and degenerate segments
        add_seek('0);
        add_window('0, TIME_MAX);
        add_load('0, TIME_MAX, '0);
        add_load(TIME_MAX, '0, {ID_W{1'b1}});
        add_load(48'd100, 48'd100, 32'd5);
        add_load(48'd100, 48'd200, 32'd5);
        add_load(48'd100, 48'd200, 32'd5);
        add_load(48'd100, 48'd150, 32'd3);
        add_load(48'd50, 48'd120, 32'd7);
        add_window('0, TIME_MAX);
        add_window(TIME_MAX, '0);
        add_window(48'd120, 48'd150);
        add_window(48'd150, 48'd150);
        add_seek('0);
        add_seek(TIME_MAX);
        add_clear();
        add_load(48'd10, 48'd20, 32'd1);
        add_seek(48'd15);
        add_seek(48'd20);
        add_seek(48'd5);
        add_window(48'd20, 48'd30);
        add_window(48'd19, 48'd20);
        n_directed = cmd_queue.size();

        // random episodes: mostly clear, a run of loads, then queries near stored points
        for (int ep = 0; cmd_queue.size() < n_directed + 220; ep++) begin
            if (ep == 0 || $urandom_range(0, 7) != 0)
                add_clear();
            sel = $urandom_range(0, 9);
            if (sel < 6)
                epoch = '0;
            else if (sel < 8)
                epoch = TIME_MAX - 48'd1000;
            else
                epoch = rand48() >> 1;
            if (ep == 0 || $urandom_range(0, 9) == 0)
                nloads = DEPTH + $urandom_range(1, 3);
            else
                nloads = $urandom_range(0, 8);
            for (int k = 0; k < nloads; k++) begin
                s   = epoch + 48'($urandom_range(0, 300));
                sel = $urandom_range(0, 15);
                if (sel == 0) begin
                    e = s;
                end else if (sel == 1) begin
                    e = s - 48'($urandom_range(1, 50));
                end else if (sel == 2) begin
                    s = rand48();
                    e = rand48();
                end else begin
                    e = s + 48'($urandom_range(1, 150));
                end
                id = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3);
                add_load(s, e, id);
            end
            nq = $urandom_range(1, 6);
            for (int q = 0; q < nq; q++) begin
                if (gen_points.size() != 0)
                    pt = gen_points[$urandom_range(0, gen_points.size() - 1)]
                         + 48'($urandom_range(0, 4)) - 48'd2;
                else
                    pt = epoch + 48'($urandom_range(0, 300));
                sel = $urandom_range(0, 19);
                if (sel < 10) begin
                    wt = pt + 48'($urandom_range(0, 150));
                    if (sel == 0)
                        add_window('0, TIME_MAX);
                    else if (sel == 1)
                        add_window(pt, pt - 48'($urandom_range(0, 30)));
                    else
                        add_window(pt, wt);
                end else if (sel < 17) begin
                    add_seek(pt);
                end else if (sel < 18) begin
                    add_seek(rand48());
                end else begin
                    queue_cmd(noise_cmd(t_func'($urandom_range(0, 3))));
                end
            end
        end
        total_count = cmd_queue.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_count)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        // longest pass sequence is a full window over a full table
        repeat (1200) @(posedge i_clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> segment_index_window_and_seek.f
hw/rtl/sixs_pkg.sv
hw/rtl/sixs_ram.sv
hw/rtl/sixs_ctrl.sv
hw/rtl/sixs_dp.sv
hw/rtl/segment_index_window_and_seek.sv
tb/sv/testbench.sv
